// ----- rtl/kpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared widths, register indexes, constants and the result type of the
// keypad scanner.
// ----------------------------------------------------------------------------
package kpsd_pkg;

	localparam int unsigned ColW   = 4;
	localparam int unsigned CodeW  = 4;
	localparam int unsigned CountW = 6;
	localparam int unsigned AsciiW = 7;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] RegDebounceTicks = 2'd0;
	localparam logic [CfgIdxW-1:0] RegReleaseTicks  = 2'd1;

	localparam logic [CountW-1:0] DebounceTicksReset = 6'd32;
	localparam logic [CountW-1:0] ReleaseTicksReset  = 6'd32;

	localparam logic [AsciiW-1:0] AsciiZero = 7'd48;
	localparam logic [AsciiW-1:0] AsciiA    = 7'd65;

	typedef struct packed {
		logic [ColW-1:0]   row_drive;
		logic [CodeW-1:0]  held_code;
		logic [AsciiW-1:0] held_ascii;
		logic              key_valid;
		logic              key_new;
		logic              key_gone;
		logic              buzzer_level;
	} result_t;

	// Hex digit in ASCII for a four-bit key code.
	function automatic logic [AsciiW-1:0] hex_ascii(input logic [CodeW-1:0] code);
		logic [AsciiW-1:0] wide;
		wide = {{(AsciiW-CodeW){1'b0}}, code};
		if (code < 4'd10)
			hex_ascii = AsciiZero + wide;
		else
			hex_ascii = AsciiA + wide - 7'd10;
	endfunction

endpackage

// ----- rtl/kpsd_core.sv -----
// ----------------------------------------------------------------------------
// kpsd_core
// Scan, debounce, release and buzzer state, updated once per stepped tick,
// together with the result of that tick.
// ----------------------------------------------------------------------------
module kpsd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kpsd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kpsd_pkg::CountW-1:0]   cfg_data,
	input  logic                          step,
	input  logic [kpsd_pkg::ColW-1:0]     column_lines,
	output kpsd_pkg::result_t             result
);

	logic [kpsd_pkg::CountW-1:0] debounce_ticks_q, release_ticks_q;
	logic [kpsd_pkg::CodeW-1:0]  scan_q, code_q;
	logic [kpsd_pkg::CountW-1:0] deb_count_q, rel_count_q;
	logic                        deb_run_q, held_q, buz_en_q, buz_pin_q;

	logic [kpsd_pkg::CodeW-1:0]  scan_d, code_d;
	logic [kpsd_pkg::CountW-1:0] deb_count_d, rel_count_d;
	logic                        deb_run_d, held_d, buz_en_d, buz_pin_d;
	logic                        pressed, is_new, is_gone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= kpsd_pkg::DebounceTicksReset;
			release_ticks_q  <= kpsd_pkg::ReleaseTicksReset;
		end else if (cfg_we) begin
			if (cfg_index == kpsd_pkg::RegDebounceTicks)
				debounce_ticks_q <= cfg_data;
			else if (cfg_index == kpsd_pkg::RegReleaseTicks)
				release_ticks_q <= cfg_data;
		end
	end

	always_comb begin
		pressed     = !column_lines[scan_q[1:0]];
		is_new      = 1'b0;
		is_gone     = 1'b0;
		code_d      = code_q;
		deb_count_d = deb_count_q;
		deb_run_d   = deb_run_q;
		rel_count_d = rel_count_q;
		held_d      = held_q;
		buz_en_d    = buz_en_q;
		// The pin toggles from the enable as it stood before this tick.
		buz_pin_d   = buz_en_q ? !buz_pin_q : buz_pin_q;

		if (!held_q) begin
			if (!deb_run_q) begin
				if (pressed) begin
					deb_run_d   = 1'b1;
					deb_count_d = debounce_ticks_q;
					code_d      = scan_q;
				end
			end else if (deb_count_q <= 6'd1) begin
				deb_run_d   = 1'b0;
				deb_count_d = '0;
				if (pressed) begin
					held_d      = 1'b1;
					buz_en_d    = 1'b1;
					rel_count_d = release_ticks_q;
					is_new      = 1'b1;
				end
			end else begin
				deb_count_d = deb_count_q - 6'd1;
			end
		end else if (pressed) begin
			rel_count_d = release_ticks_q;
		end else if (rel_count_q <= 6'd1) begin
			held_d      = 1'b0;
			buz_en_d    = 1'b0;
			rel_count_d = release_ticks_q;
			is_gone     = 1'b1;
		end else begin
			rel_count_d = rel_count_q - 6'd1;
		end

		scan_d = scan_q + 4'd1;

		result.row_drive    = ~(4'b0001 << scan_d[3:2]);
		result.held_code    = code_d;
		result.held_ascii   = kpsd_pkg::hex_ascii(code_d);
		result.key_valid    = held_d;
		result.key_new      = is_new;
		result.key_gone     = is_gone;
		result.buzzer_level = buz_pin_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			code_q      <= '0;
			deb_count_q <= '0;
			deb_run_q   <= 1'b0;
			rel_count_q <= kpsd_pkg::ReleaseTicksReset;
			held_q      <= 1'b0;
			buz_en_q    <= 1'b0;
			buz_pin_q   <= 1'b0;
		end else if (step) begin
			scan_q      <= scan_d;
			code_q      <= code_d;
			deb_count_q <= deb_count_d;
			deb_run_q   <= deb_run_d;
			rel_count_q <= rel_count_d;
			held_q      <= held_d;
			buz_en_q    <= buz_en_d;
			buz_pin_q   <= buz_pin_d;
		end
	end

endmodule

// ----- rtl/keypad_scan_debounce_top.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debounce_top
// 4x4 matrix keypad scanner with debounce, self-release and buzzer toggle.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake               Payload
//  -------  ----------------------  -------------------------------------------
//  in       in_valid / in_stall     column_lines
//  out      out_valid / out_stall   row_drive, held_code, held_ascii, key_valid,
//                                   key_new, key_gone, buzzer_level
//  cfg      cfg_we                  cfg_index, cfg_data
//
// Each item passes an input register and then the result register, which
// drives the outputs. One item can be taken every cycle while the result is
// not stalled. The scanner state advances when the input register hands
// its item on. Reset sets the scan to position zero, no key held, both
// settings and the release count to 32 and the debounce count to zero.
// A stalled result holds in the result register; the input register then
// holds too, and in_stall rises only while both stages are full.
//
module keypad_scan_debounce_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kpsd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kpsd_pkg::CountW-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kpsd_pkg::ColW-1:0]     column_lines,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kpsd_pkg::ColW-1:0]     row_drive,
	output logic [kpsd_pkg::CodeW-1:0]    held_code,
	output logic [kpsd_pkg::AsciiW-1:0]   held_ascii,
	output logic                          key_valid,
	output logic                          key_new,
	output logic                          key_gone,
	output logic                          buzzer_level
);

	logic                        valid_s1;
	logic [kpsd_pkg::ColW-1:0]   column_s1;
	logic                        valid_s2;
	kpsd_pkg::result_t           result_s2;
	kpsd_pkg::result_t           result_comb;
	logic                        advance_s1;
	logic                        take_in;

	// The input stage moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance_s1 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign take_in    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			column_s1 <= column_lines;
	end

	kpsd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.step         (advance_s1),
		.column_lines (column_s1),
		.result       (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1)
			result_s2 <= result_comb;
	end

	assign out_valid    = valid_s2;
	assign row_drive    = result_s2.row_drive;
	assign held_code    = result_s2.held_code;
	assign held_ascii   = result_s2.held_ascii;
	assign key_valid    = result_s2.key_valid;
	assign key_new      = result_s2.key_new;
	assign key_gone     = result_s2.key_gone;
	assign buzzer_level = result_s2.buzzer_level;

endmodule
